@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file of this project.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the reset is active.
`define JM_ASSERT_RST(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that holds in every cycle, reset included.
`define JM_ASSERT_CLK(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/jmts_pkg.sv @@
// Shared constants of the smoothed term score block.
// No dependencies.
`timescale 1ns / 1ps

package jmts_pkg;

	localparam int COUNT_BITS_DEF = 20;
	localparam int PROB_FRAC_DEF  = 32;
	localparam int PROB_BITS      = 32;
	localparam int WEIGHT_BITS    = 17;
	localparam int MANT_BITS      = 32;
	localparam int LOG_STEPS      = 32;
	localparam int SCORE_BITS     = 32;
	localparam int LN2_BITS       = 31;

	localparam logic [WEIGHT_BITS-1:0] ONE_Q16      = 17'h10000;
	localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = 17'h08000;
	localparam logic [SCORE_BITS-1:0]  SCORE_MIN    = 32'h80000000;
	localparam logic [LN2_BITS-1:0]    LN2_Q31      = 31'd1488522236;

endpackage

@@ hdl/jmts_div_cell.sv @@
// One restoring division cell: produces one quotient bit of the document ratio.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module jmts_div_cell #(
	parameter int CB = 20,
	parameter int QW = 52,
	parameter int PB = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [CB-1:0] in_rem,
	input  logic [CB-1:0] in_num,
	input  logic [QW-1:0] in_quo,
	input  logic [CB-1:0] in_len,
	input  logic [PB-1:0] in_prob,
	output logic          out_valid,
	output logic [CB-1:0] out_rem,
	output logic [CB-1:0] out_num,
	output logic [QW-1:0] out_quo,
	output logic [CB-1:0] out_len,
	output logic [PB-1:0] out_prob
);

	logic [CB:0]   trial;
	logic [CB:0]   diff;
	logic          ge;
	logic          valid_q;
	logic [CB-1:0] rem_q;
	logic [CB-1:0] num_q;
	logic [QW-1:0] quo_q;
	logic [CB-1:0] len_q;
	logic [PB-1:0] prob_q;

	assign trial = {in_rem, in_num[CB-1]};
	assign ge    = trial >= {1'b0, in_len};
	assign diff  = trial - {1'b0, in_len};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_q  <= ge ? diff[CB-1:0] : trial[CB-1:0];
		num_q  <= {in_num[CB-2:0], 1'b0};
		quo_q  <= {in_quo[QW-2:0], ge};
		len_q  <= in_len;
		prob_q <= in_prob;
	end

	assign out_valid = valid_q;
	assign out_rem   = rem_q;
	assign out_num   = num_q;
	assign out_quo   = quo_q;
	assign out_len   = len_q;
	assign out_prob  = prob_q;

endmodule

@@ hdl/jmts_mix.sv @@
// Two-stage mixer of the document ratio and the collection probability.
// Depends on jmts_pkg.
`timescale 1ns / 1ps

module jmts_mix #(
	parameter int QW = 52,
	parameter int MW = 53
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic [QW-1:0]                    in_ratio,
	input  logic                             in_len_zero,
	input  logic [jmts_pkg::PROB_BITS-1:0]   in_prob,
	input  logic [jmts_pkg::WEIGHT_BITS-1:0] weight,
	output logic                             out_valid,
	output logic [MW-1:0]                    out_mix
);

	import jmts_pkg::*;

	localparam int LW = QW / 2;
	localparam int HW = QW - LW;
	localparam int SW = MW + 16;

	logic [WEIGHT_BITS-1:0]    w_sat;
	logic [WEIGHT_BITS-1:0]    fw;
	logic [QW-1:0]             ratio_m;
	logic                      valid_s1;
	logic [LW+WEIGHT_BITS-1:0] plo_s1;
	logic [HW+WEIGHT_BITS-1:0] phi_s1;
	logic [PROB_BITS+WEIGHT_BITS-1:0] pw_s1;
	logic [SW-1:0]             sum;
	logic                      valid_s2;
	logic [MW-1:0]             mix_s2;

	assign w_sat   = (weight > ONE_Q16) ? ONE_Q16 : weight;
	assign fw      = ONE_Q16 - w_sat;
	assign ratio_m = in_len_zero ? '0 : in_ratio;

	assign sum = (SW'(phi_s1) << LW) + SW'(plo_s1) + SW'(pw_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		plo_s1 <= (LW+WEIGHT_BITS)'(ratio_m[LW-1:0]) * (LW+WEIGHT_BITS)'(fw);
		phi_s1 <= (HW+WEIGHT_BITS)'(ratio_m[QW-1:LW]) * (HW+WEIGHT_BITS)'(fw);
		pw_s1  <= (PROB_BITS+WEIGHT_BITS)'(in_prob) * (PROB_BITS+WEIGHT_BITS)'(w_sat);
		mix_s2 <= sum[SW-1:16];
	end

	assign out_valid = valid_s2;
	assign out_mix   = mix_s2;

endmodule

@@ hdl/jmts_norm_cell.sv @@
// One normalizing cell: shifts the mixture left by a fixed amount when its top bits are zero.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module jmts_norm_cell #(
	parameter int MW = 53,
	parameter int SH = 1,
	parameter int ZW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [MW-1:0] in_v,
	input  logic [ZW-1:0] in_z,
	output logic          out_valid,
	output logic [MW-1:0] out_v,
	output logic [ZW-1:0] out_z
);

	logic          hit;
	logic          valid_q;
	logic [MW-1:0] v_q;
	logic [ZW-1:0] z_q;

	assign hit = in_v[MW-1 -: SH] == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		v_q <= hit ? (in_v << SH) : in_v;
		z_q <= hit ? (in_z + ZW'(SH)) : in_z;
	end

	assign out_valid = valid_q;
	assign out_v     = v_q;
	assign out_z     = z_q;

endmodule

@@ hdl/jmts_log_cell.sv @@
// One squaring cell of the base-two logarithm: yields one fraction bit per item.
// Depends on jmts_pkg.
`timescale 1ns / 1ps

module jmts_log_cell #(
	parameter int TW = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [jmts_pkg::MANT_BITS-1:0] in_x,
	input  logic [jmts_pkg::MANT_BITS-1:0] in_frac,
	input  logic [TW-1:0]                  in_tag,
	output logic                           out_valid,
	output logic [jmts_pkg::MANT_BITS-1:0] out_x,
	output logic [jmts_pkg::MANT_BITS-1:0] out_frac,
	output logic [TW-1:0]                  out_tag
);

	import jmts_pkg::*;

	logic [2*MANT_BITS-1:0] sq;
	logic                   hi;
	logic                   valid_q;
	logic [MANT_BITS-1:0]   x_q;
	logic [MANT_BITS-1:0]   frac_q;
	logic [TW-1:0]          tag_q;

	assign sq = (2*MANT_BITS)'(in_x) * (2*MANT_BITS)'(in_x);
	assign hi = sq[2*MANT_BITS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		x_q    <= hi ? sq[2*MANT_BITS-1:MANT_BITS] : sq[2*MANT_BITS-2:MANT_BITS-1];
		frac_q <= {in_frac[MANT_BITS-2:0], hi};
		tag_q  <= in_tag;
	end

	assign out_valid = valid_q;
	assign out_x     = x_q;
	assign out_frac  = frac_q;
	assign out_tag   = tag_q;

endmodule

@@ hdl/jelinek_mercer_term_score_top.sv @@
// Top level of the smoothed term score block: division, mixing, normalizing and log chains.
// Depends on jmts_pkg and the jmts cell modules.
`timescale 1ns / 1ps

// The block takes one item in every cycle and never raises busy. Each result appears
// for one cycle with done high, after the division chain, the mixer, the normalizing
// chain, the 32 squaring cells of the logarithm and the output registers; the receiver
// cannot stall. The division chain yields one quotient bit per cell.
// The user must write the weight through the cfg port only while no item is in
// flight; the block itself does not enforce this.
module jelinek_mercer_term_score_top #(
	parameter int COUNT_BITS     = jmts_pkg::COUNT_BITS_DEF,
	parameter int PROB_FRAC_BITS = jmts_pkg::PROB_FRAC_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [COUNT_BITS-1:0]            term_count,
	input  logic [COUNT_BITS-1:0]            doc_length,
	input  logic [jmts_pkg::PROB_BITS-1:0]   coll_prob,
	output logic                             done,
	output logic signed [jmts_pkg::SCORE_BITS-1:0] score,
	output logic                             zero_mix,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [jmts_pkg::WEIGHT_BITS-1:0] cfg_data
);

	import jmts_pkg::*;

	localparam int QW = COUNT_BITS + PROB_FRAC_BITS;
	localparam int MW = ((QW > PROB_BITS) ? QW : PROB_BITS) + 1;
	localparam int K  = $clog2(MW);
	localparam int EW = $clog2(MW + PROB_FRAC_BITS) + 1;
	localparam int TW = EW + 1;
	localparam int HW = EW + LN2_BITS;

	logic [WEIGHT_BITS-1:0] weight_q;

	logic                  dv_valid [0:QW];
	logic [COUNT_BITS-1:0] dv_rem   [0:QW];
	logic [COUNT_BITS-1:0] dv_num   [0:QW];
	logic [QW-1:0]         dv_quo   [0:QW];
	logic [COUNT_BITS-1:0] dv_len   [0:QW];
	logic [PROB_BITS-1:0]  dv_prob  [0:QW];

	logic                  nm_valid [0:K];
	logic [MW-1:0]         nm_v     [0:K];
	logic [K-1:0]          nm_z     [0:K];

	logic                  lg_valid [0:LOG_STEPS];
	logic [MANT_BITS-1:0]  lg_x     [0:LOG_STEPS];
	logic [MANT_BITS-1:0]  lg_frac  [0:LOG_STEPS];
	logic [TW-1:0]         lg_tag   [0:LOG_STEPS];

	logic signed [EW-1:0]  e0;
	logic signed [EW+MANT_BITS-1:0] lq;
	logic                  lq_neg;
	logic [EW+MANT_BITS-1:0] lq_abs;

	logic                  valid_s1;
	logic                  zero_s1;
	logic                  neg_s1;
	logic [EW-1:0]         int_s1;
	logic [MANT_BITS-1:0]  frac_s1;

	logic                  valid_s2;
	logic                  zero_s2;
	logic                  neg_s2;
	logic [HW-1:0]         hc_s2;
	logic [MANT_BITS+LN2_BITS-1:0] lp_s2;

	logic [63:0]           t;
	logic [HW-1:0]         mag;
	logic [SCORE_BITS-1:0] mag32;

	logic                  done_s3;
	logic [SCORE_BITS-1:0] score_s3;
	logic                  zero_s3;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= WEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			weight_q <= cfg_data;
		end
	end

	assign dv_valid[0] = start && !busy;
	assign dv_rem[0]   = '0;
	assign dv_num[0]   = term_count;
	assign dv_quo[0]   = '0;
	assign dv_len[0]   = doc_length;
	assign dv_prob[0]  = coll_prob;

	for (genvar g = 0; g < QW; g++) begin : g_div
		jmts_div_cell #(.CB(COUNT_BITS), .QW(QW), .PB(PROB_BITS)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (dv_valid[g]),
			.in_rem   (dv_rem[g]),
			.in_num   (dv_num[g]),
			.in_quo   (dv_quo[g]),
			.in_len   (dv_len[g]),
			.in_prob  (dv_prob[g]),
			.out_valid(dv_valid[g+1]),
			.out_rem  (dv_rem[g+1]),
			.out_num  (dv_num[g+1]),
			.out_quo  (dv_quo[g+1]),
			.out_len  (dv_len[g+1]),
			.out_prob (dv_prob[g+1])
		);
	end

	jmts_mix #(.QW(QW), .MW(MW)) u_mix (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (dv_valid[QW]),
		.in_ratio   (dv_quo[QW]),
		.in_len_zero(dv_len[QW] == '0),
		.in_prob    (dv_prob[QW]),
		.weight     (weight_q),
		.out_valid  (nm_valid[0]),
		.out_mix    (nm_v[0])
	);

	assign nm_z[0] = '0;

	for (genvar k = 0; k < K; k++) begin : g_norm
		jmts_norm_cell #(.MW(MW), .SH(2 ** (K - 1 - k)), .ZW(K)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (nm_valid[k]),
			.in_v     (nm_v[k]),
			.in_z     (nm_z[k]),
			.out_valid(nm_valid[k+1]),
			.out_v    (nm_v[k+1]),
			.out_z    (nm_z[k+1])
		);
	end

	assign e0          = EW'(MW - 1 - PROB_FRAC_BITS) - EW'(nm_z[K]);
	assign lg_valid[0] = nm_valid[K];
	assign lg_x[0]     = nm_v[K][MW-1 -: MANT_BITS];
	assign lg_frac[0]  = '0;
	assign lg_tag[0]   = {~nm_v[K][MW-1], e0};

	for (genvar s = 0; s < LOG_STEPS; s++) begin : g_log
		jmts_log_cell #(.TW(TW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (lg_valid[s]),
			.in_x     (lg_x[s]),
			.in_frac  (lg_frac[s]),
			.in_tag   (lg_tag[s]),
			.out_valid(lg_valid[s+1]),
			.out_x    (lg_x[s+1]),
			.out_frac (lg_frac[s+1]),
			.out_tag  (lg_tag[s+1])
		);
	end

	assign lq     = {lg_tag[LOG_STEPS][EW-1:0], lg_frac[LOG_STEPS]};
	assign lq_neg = lq[EW+MANT_BITS-1];
	assign lq_abs = lq_neg ? (~lq + 1'b1) : lq;

	assign t = {1'b0, lp_s2}
		+ {{(64-7-MANT_BITS){1'b0}}, hc_s2[6:0], {MANT_BITS{1'b0}}}
		+ (64'd1 << 38);
	assign mag   = (hc_s2 >> 7) + HW'(t[63:39]);
	assign mag32 = mag[SCORE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_s3  <= 1'b0;
		end else begin
			valid_s1 <= lg_valid[LOG_STEPS];
			valid_s2 <= valid_s1;
			done_s3  <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		zero_s1  <= lg_tag[LOG_STEPS][EW];
		neg_s1   <= lq_neg;
		int_s1   <= lq_abs[EW+MANT_BITS-1:MANT_BITS];
		frac_s1  <= lq_abs[MANT_BITS-1:0];
		zero_s2  <= zero_s1;
		neg_s2   <= neg_s1;
		hc_s2    <= HW'(int_s1) * HW'(LN2_Q31);
		lp_s2    <= (MANT_BITS+LN2_BITS)'(frac_s1) * (MANT_BITS+LN2_BITS)'(LN2_Q31);
		zero_s3  <= zero_s2;
		score_s3 <= zero_s2 ? SCORE_MIN : (neg_s2 ? (~mag32 + 1'b1) : mag32);
	end

	assign done     = done_s3;
	assign score    = score_s3;
	assign zero_mix = zero_s3;

endmodule

@@ hdl/jmts_checker.sv @@
// Port-level checker of the smoothed term score block, bound to its top level.
// Depends on jmts_pkg and assert_macros.svh.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module jmts_checker #(
	parameter int CB = 20,
	parameter int FB = 32
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             start,
	input logic                             busy,
	input logic                             done,
	input logic [jmts_pkg::SCORE_BITS-1:0]  score,
	input logic                             zero_mix,
	input logic                             cfg_ready
);

	import jmts_pkg::*;

	localparam int QW  = CB + FB;
	localparam int MW  = ((QW > PROB_BITS) ? QW : PROB_BITS) + 1;
	localparam int LAT = QW + $clog2(MW) + 37;

	`JM_ASSERT_RST(a_done_latency, clk, arst_n, done |-> $past(start && !busy, LAT), "result without an item accepted at the pipeline latency")
	`JM_ASSERT_RST(a_zero_score, clk, arst_n, (done && zero_mix) |-> (score == SCORE_MIN), "zero mixture without the most negative score")
	`JM_ASSERT_RST(a_score_nonmin, clk, arst_n, (done && !zero_mix) |-> (score != SCORE_MIN), "nonzero mixture gave the most negative score")
	`JM_ASSERT_CLK(a_always_ready, clk, !busy && cfg_ready, "block refused an item or a weight write")

endmodule

bind jelinek_mercer_term_score_top jmts_checker #(
	.CB(COUNT_BITS),
	.FB(PROB_FRAC_BITS)
) u_jmts_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.score    (score),
	.zero_mix (zero_mix),
	.cfg_ready(cfg_ready)
);

@@ sim/jelinek_mercer_term_score_top_tb.sv @@
// Testbench for the smoothed term score block: directed rows and random items, each checked
// against a typed score or a fixed-point predictor of ratio, mix and natural log, across weights.
// Depends on jmts_pkg and jelinek_mercer_term_score_top.
`timescale 1ns / 1ps

module jelinek_mercer_term_score_top_tb;
	import jmts_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 120;

	typedef struct {
		logic [19:0] cnt;
		logic [19:0] len;
		logic [31:0] prob;
		bit          typed;
		logic [31:0] score;
		bit          zero;
	} term_row_t;

	typedef struct {
		logic [31:0] score;
		bit          zero;
	} term_score_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [19:0] term_count = '0;
	logic [19:0] doc_length = '0;
	logic [31:0] coll_prob = '0;
	logic        done;
	logic signed [31:0] score;
	logic        zero_mix;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [WEIGHT_BITS-1:0] cfg_data = '0;

	logic [WEIGHT_BITS-1:0] weight_q = WEIGHT_RESET;
	term_score_t expected_scores[$];
	bit          row_typed = 1'b0;
	term_score_t row_expect;
	int          errors = 0;
	int          idle_cycles = 0;
	int          item_idx = 0;

	jelinek_mercer_term_score_top u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.term_count(term_count), .doc_length(doc_length), .coll_prob(coll_prob),
		.done(done), .score(score), .zero_mix(zero_mix),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic term_score_t score_term(input logic [19:0] c, input logic [19:0] l,
			input logic [31:0] pr, input logic [WEIGHT_BITS-1:0] wt);
		logic [127:0] ratio, mix, wv;
		logic [63:0]  x, frac, lq, hc, t, mag;
		int           p, e;
		bit           neg;
		term_score_t  r;
		wv = (wt > ONE_Q16) ? 128'(ONE_Q16) : 128'(wt);
		ratio = (l != 0) ? ((128'(c) << 32) / 128'(l)) : 128'd0;
		mix = (ratio * (128'(ONE_Q16) - wv) + 128'(pr) * wv) >> 16;
		if (mix == 0) begin
			r.score = SCORE_MIN;
			r.zero = 1'b1;
			return r;
		end
		p = 0;
		for (int i = 0; i < 128; i++)
			if (mix[i]) p = i;
		if (p >= 31) x = 64'((mix >> (p - 31)) & 128'hFFFF_FFFF);
		else x = 64'((mix << (31 - p)) & 128'hFFFF_FFFF);
		frac = 0;
		for (int i = 0; i < 32; i++) begin
			x = (x * x) >> 31;
			frac = frac << 1;
			if (x >= 64'h1_0000_0000) begin
				x = x >> 1;
				frac = frac | 64'd1;
			end
		end
		e = p - 32;
		lq = {32'(e), 32'd0} + frac;
		neg = e < 0;
		if (neg) lq = -lq;
		hc = (lq >> 32) * 64'(LN2_Q31);
		t = (lq & 64'hFFFF_FFFF) * 64'(LN2_Q31) + ((hc & 64'h7F) << 32) + (64'd1 << 38);
		mag = (hc >> 7) + (t >> 39);
		r.score = neg ? 32'(-mag) : 32'(mag);
		r.zero = 1'b0;
		return r;
	endfunction

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $time, what);
		errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cfg_valid && cfg_ready) || (start && !busy) || done) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (cfg_valid && cfg_ready) begin
				weight_q <= cfg_data;
			end
			if (start && !busy) begin
				expected_scores.push_back(row_typed ? row_expect
					: score_term(term_count, doc_length, coll_prob, weight_q));
			end
			if (done) begin
				if (expected_scores.size() == 0) begin
					report($sformatf("unexpected score %h", score));
				end else begin
					term_score_t ex;
					ex = expected_scores.pop_front();
					if (score !== ex.score)
						report($sformatf("score %h, expected %h", score, ex.score));
					if (zero_mix !== ex.zero)
						report($sformatf("zero_mix %b, expected %b", zero_mix, ex.zero));
				end
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic send_term(input logic [19:0] c, input logic [19:0] l, input logic [31:0] pr,
			input bit typed, input term_score_t ex);
		int gap;
		start <= 1'b1;
		term_count <= c;
		doc_length <= l;
		coll_prob <= pr;
		row_typed <= typed;
		row_expect <= ex;
		do @(posedge clk); while (busy);
		item_idx++;
		gap = (item_idx % 100 < 20) ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_weight(input logic [WEIGHT_BITS-1:0] wt);
		start <= 1'b0;
		while (expected_scores.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= wt;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_terms(input int n);
		logic [19:0] c, l;
		logic [31:0] pr;
		term_score_t none;
		none = '{default: 0};
		repeat (n) begin
			case ($urandom_range(0, 3))
				0: begin
					c = 20'($urandom);
					l = 20'($urandom);
				end
				1: begin
					l = 20'($urandom_range(1, 1048575));
					c = 20'($urandom_range(0, l));
				end
				2: begin
					c = 20'($urandom_range(0, 15));
					l = 20'($urandom_range(0, 15));
				end
				default: begin
					l = 20'($urandom);
					c = l >> $urandom_range(0, 19);
				end
			endcase
			pr = ($urandom_range(0, 2) == 0) ? ($urandom >> $urandom_range(0, 31)) : $urandom;
			send_term(c, l, pr, 1'b0, none);
		end
	endtask

	initial begin
		term_row_t rows[$];
		term_score_t ex;
		logic [WEIGHT_BITS-1:0] weights[$];
		rows = '{
			'{20'd0, 20'd0, 32'd0, 1'b1, SCORE_MIN, 1'b1},
			'{20'd0, 20'd5, 32'd0, 1'b1, SCORE_MIN, 1'b1},
			'{20'd0, 20'hFFFFF, 32'd1, 1'b1, SCORE_MIN, 1'b1},
			'{20'd0, 20'd0, 32'hFFFFFFFF, 1'b0, 32'd0, 1'b0},
			'{20'hFFFFF, 20'd1, 32'hFFFFFFFF, 1'b0, 32'd0, 1'b0},
			'{20'd1, 20'hFFFFF, 32'd0, 1'b0, 32'd0, 1'b0},
			'{20'hFFFFF, 20'hFFFFF, 32'hFFFFFFFF, 1'b0, 32'd0, 1'b0},
			'{20'hFFFFF, 20'd0, 32'h80000000, 1'b0, 32'd0, 1'b0},
			'{20'd7, 20'd3, 32'd123, 1'b0, 32'd0, 1'b0},
			'{20'd1, 20'd1, 32'd0, 1'b0, 32'd0, 1'b0},
			'{20'd3, 20'd7, 32'h55555555, 1'b0, 32'd0, 1'b0},
			'{20'd0, 20'd1, 32'h00010000, 1'b0, 32'd0, 1'b0},
			'{20'd0, 20'd1, 32'h00000002, 1'b0, 32'd0, 1'b0},
			'{20'hAAAAA, 20'h55555, 32'hAAAAAAAA, 1'b0, 32'd0, 1'b0},
			'{20'h55555, 20'hAAAAA, 32'h55555555, 1'b0, 32'd0, 1'b0}
		};
		weights = '{17'd0, ONE_Q16, 17'h1FFFF, 17'd1, 17'hFFFF,
			17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536))};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			ex.score = rows[i].score;
			ex.zero = rows[i].zero;
			send_term(rows[i].cnt, rows[i].len, rows[i].prob, rows[i].typed, ex);
		end
		random_terms(40);
		foreach (weights[i]) begin
			write_weight(weights[i]);
			random_terms(56);
		end
		start <= 1'b0;
		while (expected_scores.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

@@ jelinek_mercer_term_score_top.f @@
+incdir+hdl
hdl/jmts_pkg.sv
hdl/jmts_div_cell.sv
hdl/jmts_mix.sv
hdl/jmts_norm_cell.sv
hdl/jmts_log_cell.sv
hdl/jelinek_mercer_term_score_top.sv
hdl/jmts_checker.sv
sim/jelinek_mercer_term_score_top_tb.sv
